/* hw/rtl/wfr_pkg.sv */
// ----------------------------------------------------------------------------
// Wall-following rover navigation package
// Field widths, event codes, motion commands, navigation state codes and
// configuration indexes that the channel interfaces and the core share.
// ----------------------------------------------------------------------------
package wfr_pkg;

    localparam int unsigned OpcodeW   = 3;
    localparam int unsigned DistW     = 8;
    localparam int unsigned TrendW    = 8;
    localparam int unsigned LapW      = 4;
    localparam int unsigned CmdW      = 3;
    localparam int unsigned TicksW    = 8;
    localparam int unsigned StateW    = 4;
    localparam int unsigned TrendLimW = 7;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 8;

    // Event codes.
    localparam logic [OpcodeW-1:0] OP_TICK_DONE   = 3'd0;
    localparam logic [OpcodeW-1:0] OP_START       = 3'd1;
    localparam logic [OpcodeW-1:0] OP_RESET       = 3'd2;
    localparam logic [OpcodeW-1:0] OP_SENSOR      = 3'd3;
    localparam logic [OpcodeW-1:0] OP_TURN_DONE   = 3'd4;
    localparam logic [OpcodeW-1:0] OP_COLOUR_LINE = 3'd5;

    // Motion commands.
    localparam logic [CmdW-1:0] CMD_NONE      = 3'd0;
    localparam logic [CmdW-1:0] CMD_FORWARD   = 3'd1;
    localparam logic [CmdW-1:0] CMD_STOP      = 3'd2;
    localparam logic [CmdW-1:0] CMD_RIGHT90   = 3'd3;
    localparam logic [CmdW-1:0] CMD_LEFT90    = 3'd4;
    localparam logic [CmdW-1:0] CMD_ADJ_RIGHT = 3'd5;
    localparam logic [CmdW-1:0] CMD_ADJ_LEFT  = 3'd6;

    // Navigation states.
    localparam logic [StateW-1:0] ST_IDLE       = 4'd0;
    localparam logic [StateW-1:0] ST_CRUISE     = 4'd1;
    localparam logic [StateW-1:0] ST_WAIT_WALL  = 4'd2;
    localparam logic [StateW-1:0] ST_FIND_WALL  = 4'd3;
    localparam logic [StateW-1:0] ST_TURN_LEFT  = 4'd4;
    localparam logic [StateW-1:0] ST_TURN_RIGHT = 4'd5;
    localparam logic [StateW-1:0] ST_ADJUST     = 4'd6;
    localparam logic [StateW-1:0] ST_MOVE_AWAY  = 4'd7;
    localparam logic [StateW-1:0] ST_END        = 4'd8;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_FRONT_CLOSE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RIGHT_CLOSE = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_WALL_FOUND  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RIGHT_OPEN  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TREND_LIM   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_FINISH_LAP  = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_SEARCH_TCK  = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_AWAY_TCK    = 3'd7;

    typedef struct packed {
        logic [OpcodeW-1:0] opcode;
        logic [DistW-1:0]   front_distance;
        logic [DistW-1:0]   right_distance;
        logic [TrendW-1:0]  right_trend;
        logic [LapW-1:0]    lap_count;
    } t_event;

    typedef struct packed {
        logic [CmdW-1:0]   motion_command;
        logic [TicksW-1:0] tick_request;
        logic [StateW-1:0] state_code;
        logic              unexpected_event;
    } t_result;

endpackage

/* hw/rtl/wfr_if.sv */
// ----------------------------------------------------------------------------
// Wall-following rover channel interfaces
// Valid/ready channels for events, results and configuration writes.
// ----------------------------------------------------------------------------
interface wfr_event_if;
    logic                            valid;
    logic                            ready;
    logic [wfr_pkg::OpcodeW-1:0]     opcode;
    logic [wfr_pkg::DistW-1:0]       front_distance;
    logic [wfr_pkg::DistW-1:0]       right_distance;
    logic signed [wfr_pkg::TrendW-1:0] right_trend;
    logic [wfr_pkg::LapW-1:0]        lap_count;

    modport source (output valid, opcode, front_distance, right_distance,
                    right_trend, lap_count, input ready);
    modport sink   (input valid, opcode, front_distance, right_distance,
                    right_trend, lap_count, output ready);
endinterface

interface wfr_result_if;
    logic                        valid;
    logic                        ready;
    logic [wfr_pkg::CmdW-1:0]    motion_command;
    logic [wfr_pkg::TicksW-1:0]  tick_request;
    logic [wfr_pkg::StateW-1:0]  state_code;
    logic                        unexpected_event;

    modport source (output valid, motion_command, tick_request, state_code,
                    unexpected_event, input ready);
    modport sink   (input valid, motion_command, tick_request, state_code,
                    unexpected_event, output ready);
endinterface

interface wfr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [wfr_pkg::CfgIdxW-1:0]  index;
    logic [wfr_pkg::CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/wall_following_rover_fsm_core.sv */
// ----------------------------------------------------------------------------
// Wall-following rover navigation core
// Navigation state machine: one motion result for every event transfer.
// ----------------------------------------------------------------------------
// The core takes one event per clock while the output is not stalled and
// returns exactly one result per event: the event is captured in an input
// register, decided against the current navigation state and the limit
// registers in one pass of comparisons, and the result lands in the output
// register together with the state update. Back-to-back events are handled
// at full rate because the state register is updated in the same cycle the
// result is written. Limits are written through the configuration channel,
// which is always ready, and must only be changed while no event is in flight.
module wall_following_rover_fsm_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wfr_event_if.sink            i_in,
    wfr_result_if.source         o_out,
    wfr_cfg_if.sink              i_cfg
);

    // Configuration registers.
    logic [wfr_pkg::DistW-1:0]     r_front_close;
    logic [wfr_pkg::DistW-1:0]     r_right_close;
    logic [wfr_pkg::DistW-1:0]     r_wall_found;
    logic [wfr_pkg::DistW-1:0]     r_right_open;
    logic [wfr_pkg::TrendLimW-1:0] r_trend_lim;
    logic [wfr_pkg::LapW-1:0]      r_finish_lap;
    logic [wfr_pkg::TicksW-1:0]    r_search_ticks;
    logic [wfr_pkg::TicksW-1:0]    r_away_ticks;

    logic [wfr_pkg::StateW-1:0]    r_state;
    logic [wfr_pkg::StateW-1:0]    n_state;

    logic                          r_ev_valid;
    wfr_pkg::t_event               r_ev;
    logic                          r_out_valid;
    wfr_pkg::t_result              r_out;
    wfr_pkg::t_result              n_out;

    logic                          ev_advance;
    logic                          in_ready;
    logic                          cfg_we;

    assign cfg_we     = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_close  <= 8'd18;
            r_right_close  <= 8'd38;
            r_wall_found   <= 8'd70;
            r_right_open   <= 8'd106;
            r_trend_lim    <= 7'd5;
            r_finish_lap   <= 4'd3;
            r_search_ticks <= 8'd50;
            r_away_ticks   <= 8'd10;
        end else if (cfg_we) begin
            case (i_cfg.index)
                wfr_pkg::CFG_FRONT_CLOSE: r_front_close  <= i_cfg.data;
                wfr_pkg::CFG_RIGHT_CLOSE: r_right_close  <= i_cfg.data;
                wfr_pkg::CFG_WALL_FOUND:  r_wall_found   <= i_cfg.data;
                wfr_pkg::CFG_RIGHT_OPEN:  r_right_open   <= i_cfg.data;
                wfr_pkg::CFG_TREND_LIM:   r_trend_lim    <= i_cfg.data[wfr_pkg::TrendLimW-1:0];
                wfr_pkg::CFG_FINISH_LAP:  r_finish_lap   <= i_cfg.data[wfr_pkg::LapW-1:0];
                wfr_pkg::CFG_SEARCH_TCK:  r_search_ticks <= i_cfg.data;
                wfr_pkg::CFG_AWAY_TCK:    r_away_ticks   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Pipeline handshake: each register accepts when empty or draining.
    assign ev_advance = r_ev_valid && (!r_out_valid || o_out.ready);
    assign in_ready   = !r_ev_valid || ev_advance;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (in_ready) begin
            r_ev_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_ev.opcode         <= i_in.opcode;
            r_ev.front_distance <= i_in.front_distance;
            r_ev.right_distance <= i_in.right_distance;
            r_ev.right_trend    <= i_in.right_trend;
            r_ev.lap_count      <= i_in.lap_count;
        end
    end

    // Decision logic for one event.
    logic signed [wfr_pkg::TrendW:0] trend_x;
    logic signed [wfr_pkg::TrendW:0] lim_pos;
    logic signed [wfr_pkg::TrendW:0] lim_neg;
    logic                            front_close;
    logic                            may_turn;

    always_comb begin
        trend_x     = {r_ev.right_trend[wfr_pkg::TrendW-1], r_ev.right_trend};
        lim_pos     = {2'b00, r_trend_lim};
        lim_neg     = -lim_pos;
        front_close = r_ev.front_distance < r_front_close;
        may_turn    = 1'b1;
        n_state     = r_state;
        n_out       = '0;
        case (r_ev.opcode)
            wfr_pkg::OP_TICK_DONE: begin
                if (r_state == wfr_pkg::ST_MOVE_AWAY) begin
                    n_out.motion_command = wfr_pkg::CMD_RIGHT90;
                    n_state = wfr_pkg::ST_TURN_RIGHT;
                end else if (r_state == wfr_pkg::ST_FIND_WALL) begin
                    n_state = wfr_pkg::ST_CRUISE;
                end
            end
            wfr_pkg::OP_START: begin
                n_out.motion_command = wfr_pkg::CMD_FORWARD;
                n_state = wfr_pkg::ST_CRUISE;
            end
            wfr_pkg::OP_RESET: begin
                n_out.motion_command = wfr_pkg::CMD_STOP;
                n_state = wfr_pkg::ST_IDLE;
            end
            wfr_pkg::OP_SENSOR: begin
                if (r_state inside {wfr_pkg::ST_CRUISE, wfr_pkg::ST_WAIT_WALL,
                                    wfr_pkg::ST_FIND_WALL}) begin
                    if (r_state == wfr_pkg::ST_FIND_WALL) begin
                        if (r_ev.right_distance < r_wall_found) begin
                            n_state = wfr_pkg::ST_CRUISE;
                        end else begin
                            may_turn = 1'b0;
                        end
                    end
                    if (front_close) begin
                        n_out.motion_command = wfr_pkg::CMD_LEFT90;
                        n_state = wfr_pkg::ST_TURN_LEFT;
                    end else if (may_turn) begin
                        // A found wall counts as cruise for the rest of the decision.
                        if (r_ev.right_distance >= r_right_open) begin
                            if (n_state == wfr_pkg::ST_CRUISE) begin
                                n_state = wfr_pkg::ST_WAIT_WALL;
                            end else begin
                                n_out.motion_command = wfr_pkg::CMD_RIGHT90;
                                n_state = wfr_pkg::ST_TURN_RIGHT;
                            end
                        end else if (trend_x > lim_pos) begin
                            n_out.motion_command = wfr_pkg::CMD_ADJ_RIGHT;
                            n_state = wfr_pkg::ST_ADJUST;
                        end else if (trend_x < lim_neg) begin
                            n_out.motion_command = wfr_pkg::CMD_ADJ_LEFT;
                            n_state = wfr_pkg::ST_ADJUST;
                        end else if (r_ev.right_distance < r_right_close) begin
                            n_out.motion_command = wfr_pkg::CMD_LEFT90;
                            n_state = wfr_pkg::ST_MOVE_AWAY;
                        end
                    end
                end
            end
            wfr_pkg::OP_TURN_DONE: begin
                if (r_state inside {wfr_pkg::ST_TURN_LEFT, wfr_pkg::ST_TURN_RIGHT}) begin
                    n_state = wfr_pkg::ST_FIND_WALL;
                    n_out.tick_request   = r_search_ticks;
                    n_out.motion_command = wfr_pkg::CMD_FORWARD;
                end else if (r_state == wfr_pkg::ST_ADJUST) begin
                    n_state = wfr_pkg::ST_CRUISE;
                    n_out.motion_command = wfr_pkg::CMD_FORWARD;
                end else if (r_state == wfr_pkg::ST_MOVE_AWAY) begin
                    n_out.tick_request   = r_away_ticks;
                    n_out.motion_command = wfr_pkg::CMD_FORWARD;
                end else begin
                    n_out.unexpected_event = 1'b1;
                end
            end
            wfr_pkg::OP_COLOUR_LINE: begin
                if (r_ev.lap_count == r_finish_lap) begin
                    n_state = wfr_pkg::ST_END;
                    n_out.motion_command = wfr_pkg::CMD_STOP;
                end
            end
            default: ;
        endcase
        n_out.state_code = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wfr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (ev_advance) begin
                r_state <= n_state;
            end
            if (ev_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.motion_command   = r_out.motion_command;
    assign o_out.tick_request     = r_out.tick_request;
    assign o_out.state_code       = r_out.state_code;
    assign o_out.unexpected_event = r_out.unexpected_event;

    // A turn-complete in the wrong state must not move the rover.
    a_unexp_no_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.unexpected_event |-> o_out.motion_command == wfr_pkg::CMD_NONE)
        else $error("unexpected event carries a motion command");

    // A tick wait is only requested alongside a forward command.
    a_ticks_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.tick_request != '0 |->
            o_out.motion_command == wfr_pkg::CMD_FORWARD)
        else $error("tick request without forward command");

    // The reported state always matches the state register once delivered.
    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_advance |=> r_state == o_out.state_code)
        else $error("result state differs from navigation state");

    // A reset event always returns the machine to idle.
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_advance && r_ev.opcode == wfr_pkg::OP_RESET |=> r_state == wfr_pkg::ST_IDLE)
        else $error("reset event did not return to idle");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the wall-following rover navigation core
// A directed table of events is followed by random event sequences under
// several limit settings and idle/stall mixes. Every result is compared
// with the next queued entry: a typed directed row's result or the prediction.
// ----------------------------------------------------------------------------
module tb;
    import wfr_pkg::*;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int NDIR            = 26;
    localparam int MAX_PRINTED     = 40;

    // Opcodes the core must treat as no-ops.
    localparam logic [OpcodeW-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OpcodeW-1:0] OP_UNUSED_7 = 3'd7;

    localparam t_result NO_RES = '0;

    typedef struct packed {
        t_event  ev;
        logic    typed;
        t_result res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    wfr_event_if  ev_if ();
    wfr_result_if res_if ();
    wfr_cfg_if    cfg_if ();

    wall_following_rover_fsm_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    // Predictor copy of the navigation state and the limit registers.
    logic [StateW-1:0]    nav_q;
    logic [DistW-1:0]     lim_front_close;
    logic [DistW-1:0]     lim_right_close;
    logic [DistW-1:0]     lim_wall_found;
    logic [DistW-1:0]     lim_right_open;
    logic [TrendLimW-1:0] lim_trend;
    logic [LapW-1:0]      lim_finish_lap;
    logic [TicksW-1:0]    lim_search_ticks;
    logic [TicksW-1:0]    lim_away_ticks;

    t_result pending_results [$];
    int      error_count;
    int      cycle_count = 0;
    int      idle_pct;
    int      stall_pct;

    // Directed events; rows with typed set carry their expected result.
    t_dir_row directed_rows [NDIR] = '{
        {OP_TURN_DONE,   8'd0,   8'd0,   8'h00, 4'd0, 1'b1, CMD_NONE,    8'd0, ST_IDLE,   1'b1},
        {OP_UNUSED_6,    8'hFF,  8'hFF,  8'hFF, 4'hF, 1'b1, CMD_NONE,    8'd0, ST_IDLE,   1'b0},
        {OP_UNUSED_7,    8'd0,   8'd0,   8'h00, 4'd0, 1'b1, CMD_NONE,    8'd0, ST_IDLE,   1'b0},
        {OP_SENSOR,      8'd0,   8'd0,   8'h00, 4'd0, 1'b1, CMD_NONE,    8'd0, ST_IDLE,   1'b0},
        {OP_TICK_DONE,   8'd0,   8'd0,   8'h00, 4'd0, 1'b1, CMD_NONE,    8'd0, ST_IDLE,   1'b0},
        {OP_COLOUR_LINE, 8'd0,   8'd0,   8'h00, 4'd2, 1'b1, CMD_NONE,    8'd0, ST_IDLE,   1'b0},
        {OP_START,       8'd0,   8'd0,   8'h00, 4'd0, 1'b1, CMD_FORWARD, 8'd0, ST_CRUISE, 1'b0},
        {OP_SENSOR,      8'd0,   8'd0,   8'h00, 4'd0, 1'b0, NO_RES},
        {OP_TURN_DONE,   8'd0,   8'd0,   8'h00, 4'd0, 1'b0, NO_RES},
        {OP_SENSOR,      8'd255, 8'd255, 8'h7F, 4'd0, 1'b0, NO_RES},
        {OP_TICK_DONE,   8'd0,   8'd0,   8'h00, 4'd0, 1'b0, NO_RES},
        {OP_SENSOR,      8'd255, 8'd255, 8'h00, 4'd0, 1'b0, NO_RES},
        {OP_SENSOR,      8'd255, 8'd106, 8'h00, 4'd0, 1'b0, NO_RES},
        {OP_TURN_DONE,   8'd0,   8'd0,   8'h00, 4'd0, 1'b0, NO_RES},
        {OP_SENSOR,      8'd200, 8'd20,  8'h00, 4'd0, 1'b0, NO_RES},
        {OP_TURN_DONE,   8'd0,   8'd0,   8'h00, 4'd0, 1'b0, NO_RES},
        {OP_TICK_DONE,   8'd0,   8'd0,   8'h00, 4'd0, 1'b0, NO_RES},
        {OP_TURN_DONE,   8'd0,   8'd0,   8'h00, 4'd0, 1'b0, NO_RES},
        {OP_SENSOR,      8'd100, 8'd69,  8'h7F, 4'd0, 1'b0, NO_RES},
        {OP_TURN_DONE,   8'd0,   8'd0,   8'h00, 4'd0, 1'b0, NO_RES},
        {OP_SENSOR,      8'd18,  8'd80,  8'h80, 4'd0, 1'b0, NO_RES},
        {OP_TURN_DONE,   8'd0,   8'd0,   8'h00, 4'd0, 1'b0, NO_RES},
        {OP_COLOUR_LINE, 8'd0,   8'd0,   8'h00, 4'd3, 1'b1, CMD_STOP,    8'd0, ST_END,    1'b0},
        {OP_START,       8'd0,   8'd0,   8'h00, 4'd0, 1'b1, CMD_FORWARD, 8'd0, ST_CRUISE, 1'b0},
        {OP_COLOUR_LINE, 8'd0,   8'd0,   8'h00, 4'd3, 1'b1, CMD_STOP,    8'd0, ST_END,    1'b0},
        {OP_RESET,       8'd0,   8'd0,   8'h00, 4'd0, 1'b1, CMD_STOP,    8'd0, ST_IDLE,   1'b0}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // Works out the result of one event and advances the predicted state.
    function automatic t_result predict_nav(input t_event ev);
        t_result           r;
        logic [StateW-1:0] s;
        int                trend;
        int                tl;
        bit                may_turn;
        bit                active;
        r        = '0;
        s        = nav_q;
        trend    = int'($signed(ev.right_trend));
        tl       = int'(lim_trend);
        may_turn = 1'b1;
        active   = 1'b1;
        case (ev.opcode)
            OP_TICK_DONE: begin
                if (s == ST_MOVE_AWAY) begin
                    r.motion_command = CMD_RIGHT90;
                    s = ST_TURN_RIGHT;
                end else if (s == ST_FIND_WALL) begin
                    s = ST_CRUISE;
                end
            end
            OP_START: begin
                r.motion_command = CMD_FORWARD;
                s = ST_CRUISE;
            end
            OP_RESET: begin
                r.motion_command = CMD_STOP;
                s = ST_IDLE;
            end
            OP_SENSOR: begin
                if (s == ST_FIND_WALL) begin
                    if (ev.right_distance < lim_wall_found)
                        s = ST_CRUISE;
                    else
                        may_turn = 1'b0;
                end else if (s != ST_CRUISE && s != ST_WAIT_WALL) begin
                    active = 1'b0;
                end
                if (active) begin
                    if (ev.front_distance < lim_front_close) begin
                        r.motion_command = CMD_LEFT90;
                        s = ST_TURN_LEFT;
                    end else if (may_turn) begin
                        if (ev.right_distance >= lim_right_open) begin
                            // An open right side needs a second open reading before the right turn.
                            if (s == ST_CRUISE) begin
                                s = ST_WAIT_WALL;
                            end else if (s == ST_WAIT_WALL) begin
                                r.motion_command = CMD_RIGHT90;
                                s = ST_TURN_RIGHT;
                            end
                        end else if (trend > tl) begin
                            r.motion_command = CMD_ADJ_RIGHT;
                            s = ST_ADJUST;
                        end else if (trend < -tl) begin
                            r.motion_command = CMD_ADJ_LEFT;
                            s = ST_ADJUST;
                        end else if (ev.right_distance < lim_right_close) begin
                            r.motion_command = CMD_LEFT90;
                            s = ST_MOVE_AWAY;
                        end
                    end
                end
            end
            OP_TURN_DONE: begin
                if (s == ST_TURN_LEFT || s == ST_TURN_RIGHT) begin
                    s = ST_FIND_WALL;
                    r.tick_request = lim_search_ticks;
                    r.motion_command = CMD_FORWARD;
                end else if (s == ST_ADJUST) begin
                    s = ST_CRUISE;
                    r.motion_command = CMD_FORWARD;
                end else if (s == ST_MOVE_AWAY) begin
                    r.tick_request = lim_away_ticks;
                    r.motion_command = CMD_FORWARD;
                end else begin
                    r.unexpected_event = 1'b1;
                end
            end
            OP_COLOUR_LINE: begin
                if (ev.lap_count == lim_finish_lap) begin
                    s = ST_END;
                    r.motion_command = CMD_STOP;
                end
            end
            default: ;
        endcase
        nav_q = s;
        r.state_code = s;
        return r;
    endfunction

    // Values at, just around, and at the ends of a limit.
    function automatic logic [7:0] near_limit(input logic [7:0] lim);
        logic [7:0] v;
        case ($urandom_range(4))
            0:       v = 8'd0;
            1:       v = 8'd255;
            2:       v = lim - 8'd1;
            3:       v = lim;
            default: v = lim + 8'd1;
        endcase
        return v;
    endfunction

    // Mostly events that fit the predicted state, with some noise.
    function automatic t_event next_rover_event();
        t_event ev;
        int     pick;
        int     t;
        ev.opcode         = 3'($urandom_range(7));
        ev.front_distance = 8'($urandom_range(255));
        ev.right_distance = 8'($urandom_range(255));
        ev.right_trend    = 8'($urandom_range(255));
        ev.lap_count      = 4'($urandom_range(15));
        pick = int'($urandom_range(99));
        if (pick >= 10) begin
            case (nav_q)
                ST_IDLE, ST_END:
                    ev.opcode = OP_START;
                ST_TURN_LEFT, ST_TURN_RIGHT, ST_ADJUST:
                    ev.opcode = (pick < 85) ? OP_TURN_DONE : OP_SENSOR;
                ST_MOVE_AWAY:
                    ev.opcode = (pick < 55) ? OP_TURN_DONE : OP_TICK_DONE;
                ST_FIND_WALL:
                    ev.opcode = (pick < 35) ? OP_TICK_DONE : OP_SENSOR;
                default:
                    ev.opcode = (pick < 97) ? OP_SENSOR : OP_COLOUR_LINE;
            endcase
        end
        if (ev.opcode == OP_COLOUR_LINE && $urandom_range(1) == 1)
            ev.lap_count = lim_finish_lap;
        if (ev.opcode == OP_SENSOR && $urandom_range(1) == 1) begin
            ev.front_distance = near_limit(lim_front_close);
            case ($urandom_range(3))
                0:       ev.right_distance = near_limit(lim_right_close);
                1:       ev.right_distance = near_limit(lim_wall_found);
                2:       ev.right_distance = near_limit(lim_right_open);
                default: ev.right_distance = 8'($urandom_range(int'(lim_right_open)));
            endcase
            case ($urandom_range(2))
                0: begin
                    t = int'(lim_trend) + int'($urandom_range(2)) - 1;
                    if ($urandom_range(1) == 1)
                        t = -t;
                    ev.right_trend = 8'(t);
                end
                1:       ev.right_trend = 8'h00;
                default: ;
            endcase
        end
        return ev;
    endfunction

    // Called just after the clock rises; returns when the core has taken the event.
    task automatic send_event(input t_event ev, input bit typed, input t_result typed_res);
        t_result pred;
        while ($urandom_range(99) < idle_pct) begin
            ev_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        ev_if.valid          <= 1'b1;
        ev_if.opcode         <= ev.opcode;
        ev_if.front_distance <= ev.front_distance;
        ev_if.right_distance <= ev.right_distance;
        ev_if.right_trend    <= ev.right_trend;
        ev_if.lap_count      <= ev.lap_count;
        do @(posedge i_clk); while (ev_if.ready !== 1'b1);
        pred = predict_nav(ev);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic write_limits(input logic [CfgDataW-1:0] vals [8]);
        int k;
        for (k = 0; k < 8; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= CfgIdxW'(k);
            cfg_if.data  <= vals[k];
            do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
            case (CfgIdxW'(k))
                CFG_FRONT_CLOSE: lim_front_close  = vals[k];
                CFG_RIGHT_CLOSE: lim_right_close  = vals[k];
                CFG_WALL_FOUND:  lim_wall_found   = vals[k];
                CFG_RIGHT_OPEN:  lim_right_open   = vals[k];
                CFG_TREND_LIM:   lim_trend        = vals[k][TrendLimW-1:0];
                CFG_FINISH_LAP:  lim_finish_lap   = vals[k][LapW-1:0];
                CFG_SEARCH_TCK:  lim_search_ticks = vals[k];
                CFG_AWAY_TCK:    lim_away_ticks   = vals[k];
                default: ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Result side: random back-pressure and the in-order compare.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got = {res_if.motion_command, res_if.tick_request, res_if.state_code,
                   res_if.unexpected_event};
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %h", got));
            end else begin
                want = pending_results.pop_front();
                if (got.motion_command !== want.motion_command
                        || got.tick_request !== want.tick_request
                        || got.state_code !== want.state_code
                        || got.unexpected_event !== want.unexpected_event)
                    report_mismatch($sformatf(
                        "cmd %0d/%0d ticks %0d/%0d state %0d/%0d unexp %0d/%0d (got/exp)",
                        got.motion_command, want.motion_command,
                        got.tick_request, want.tick_request,
                        got.state_code, want.state_code,
                        got.unexpected_event, want.unexpected_event));
            end
        end
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        logic [CfgDataW-1:0] vals [8];
        int                  n;
        int                  ph;
        int                  k;
        t_dir_row            row;

        error_count = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        nav_q            = ST_IDLE;
        lim_front_close  = 8'd18;
        lim_right_close  = 8'd38;
        lim_wall_found   = 8'd70;
        lim_right_open   = 8'd106;
        lim_trend        = 7'd5;
        lim_finish_lap   = 4'd3;
        lim_search_ticks = 8'd50;
        lim_away_ticks   = 8'd10;

        i_rst_n              <= 1'b0;
        ev_if.valid          <= 1'b0;
        ev_if.opcode         <= OP_TICK_DONE;
        ev_if.front_distance <= '0;
        ev_if.right_distance <= '0;
        ev_if.right_trend    <= '0;
        ev_if.lap_count      <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= CFG_FRONT_CLOSE;
        cfg_if.data          <= '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < NDIR; n++) begin
            row = directed_rows[n];
            send_event(row.ev, row.typed, row.res);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            // Limits change only once the core has drained.
            ev_if.valid <= 1'b0;
            do @(posedge i_clk); while (pending_results.size() != 0);
            case (ph)
                0: vals = '{8'd18, 8'd38, 8'd70, 8'd106, 8'd5, 8'd3, 8'd50, 8'd10};
                1: for (k = 0; k < 8; k++) vals[k] = 8'h00;
                2: for (k = 0; k < 8; k++) vals[k] = 8'hFF;
                default: begin
                    for (k = 0; k < 8; k++) vals[k] = 8'($urandom_range(255));
                    if ($urandom_range(1) == 1)
                        vals[CFG_TREND_LIM] = 8'($urandom_range(12));
                end
            endcase
            write_limits(vals);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
                    // Hold the sender until every pending result is out.
                    ev_if.valid <= 1'b0;
                    do @(posedge i_clk); while (pending_results.size() != 0);
                end
                send_event(next_rover_event(), 1'b0, NO_RES);
            end
        end

        ev_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
